### sv/sfpc_pkg.sv
// ============================================================================
// sfpc_pkg
// Shared types, codes and fixed-point helpers for the scope front panel.
// ============================================================================
package sfpc_pkg;

    // Adjust mode codes
    localparam logic [1:0] MODE_TIMEBASE = 2'd0;
    localparam logic [1:0] MODE_VOLT     = 2'd1;
    localparam logic [1:0] MODE_TRIGGER  = 2'd2;

    // Channel selection codes
    localparam logic [1:0] CHAN_ONE  = 2'd0;
    localparam logic [1:0] CHAN_TWO  = 2'd1;
    localparam logic [1:0] CHAN_BOTH = 2'd2;

    // Reset values of the parameter registers
    localparam logic [13:0] TIMEBASE_RESET = 14'd1000;
    localparam logic [13:0] VOLT_RESET     = 14'd1000;
    localparam logic [11:0] TRIGGER_RESET  = 12'd1650;

    // Pot mapping spans and offsets
    localparam logic [25:0] TIMEBASE_SPAN   = 26'd9900;
    localparam logic [25:0] VOLT_SPAN       = 26'd9500;
    localparam logic [25:0] POT_SPAN        = 26'd3300;
    localparam logic [13:0] TIMEBASE_OFFSET = 14'd100;
    localparam logic [13:0] VOLT_OFFSET     = 14'd500;
    localparam logic [12:0] FULL_SCALE      = 13'd4095;

    // Input transaction
    typedef struct packed {
        logic        mode_button_level;
        logic        channel_button_level;
        logic        run_button_level;
        logic [11:0] pot_sample;
    } in_t;

    // Result transaction
    typedef struct packed {
        logic [1:0]  adjust_mode;
        logic [1:0]  channel_select;
        logic        running;
        logic [13:0] timebase_us;
        logic [13:0] volt_scale_mv;
        logic [11:0] trigger_mv;
        logic [11:0] pot_mv;
    } out_t;

    // Mapped pot values for one sample
    typedef struct packed {
        logic [13:0] timebase_us;
        logic [13:0] volt_scale_mv;
        logic [11:0] pot_mv;
    } scale_t;

    // Exact floor(x / 4095) for x below 3 * 2^24, using 4095 = 4096 - 1:
    // fold the high part back in twice, then one compare-and-bump.
    function automatic logic [13:0] div4095(input logic [25:0] x);
        logic [13:0] q1;
        logic [13:0] r1;
        logic [1:0]  q2;
        logic [12:0] r2;
        logic        bump;
        q1   = x[25:12];
        r1   = {2'b00, x[11:0]} + q1;
        q2   = r1[13:12];
        r2   = {1'b0, r1[11:0]} + {11'd0, q2};
        bump = (r2 >= FULL_SCALE);
        return q1 + {12'd0, q2} + {13'd0, bump};
    endfunction

    // Advance a modulo-three selector
    function automatic logic [1:0] next_mod3(input logic [1:0] v);
        return (v >= 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

endpackage

### sv/sfpc_in_reg.sv
// ============================================================================
// sfpc_in_reg
// Input register: captures one poll transaction and holds it until the
// panel stage takes it.
// ============================================================================
module sfpc_in_reg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sfpc_pkg::in_t s_data,
    input  logic          take,
    output logic          hold_valid,
    output sfpc_pkg::in_t hold_data
);

    logic          valid_reg;
    logic          valid_next;
    sfpc_pkg::in_t data_reg;

    // Open the slot when empty or when its transaction moves on this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= s_data;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

endmodule

### sv/sfpc_scale.sv
// ============================================================================
// sfpc_scale
// Linear pot mappings: constant multiply, then exact divide by full scale.
// ============================================================================
module sfpc_scale (
    input  logic [11:0]      pot_sample,
    output sfpc_pkg::scale_t mapped
);

    logic [25:0] sample_wide;
    logic [13:0] tb_q;
    logic [13:0] volt_q;
    logic [13:0] pot_q;

    assign sample_wide = {14'd0, pot_sample};

    // Scale each span; products stay below 2^26
    assign tb_q   = sfpc_pkg::div4095(sample_wide * sfpc_pkg::TIMEBASE_SPAN);
    assign volt_q = sfpc_pkg::div4095(sample_wide * sfpc_pkg::VOLT_SPAN);
    assign pot_q  = sfpc_pkg::div4095(sample_wide * sfpc_pkg::POT_SPAN);

    assign mapped.timebase_us   = sfpc_pkg::TIMEBASE_OFFSET + tb_q;
    assign mapped.volt_scale_mv = sfpc_pkg::VOLT_OFFSET + volt_q;
    assign mapped.pot_mv        = pot_q[11:0];

endmodule

### sv/sfpc_panel.sv
// ============================================================================
// sfpc_panel
// Panel state: button edge detection, mode/channel/run update, parameter
// registers and the result register.
// ============================================================================
module sfpc_panel (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             hold_valid,
    input  sfpc_pkg::in_t    hold_data,
    input  sfpc_pkg::scale_t mapped,
    output logic             take,
    output logic             m_valid,
    input  logic             m_ready,
    output sfpc_pkg::out_t   m_data
);

    logic [2:0]     prev_levels_reg;
    logic [1:0]     mode_reg;
    logic [1:0]     channel_reg;
    logic           run_reg;
    logic [13:0]    timebase_reg;
    logic [13:0]    volt_reg;
    logic [11:0]    trigger_reg;
    logic           out_valid_reg;
    sfpc_pkg::out_t out_reg;

    logic [1:0]     mode_next;
    logic [1:0]     channel_next;
    logic           run_next;
    logic [13:0]    timebase_next;
    logic [13:0]    volt_next;
    logic [11:0]    trigger_next;
    logic           out_valid_next;
    logic           mode_press;
    logic           channel_press;
    logic           run_press;

    // Advance when the result register is free or being drained
    assign take = hold_valid && (!out_valid_reg || m_ready);

    // Detect presses as falling edges of the active-low levels
    assign mode_press    = prev_levels_reg[0] && !hold_data.mode_button_level;
    assign channel_press = prev_levels_reg[1] && !hold_data.channel_button_level;
    assign run_press     = prev_levels_reg[2] && !hold_data.run_button_level;

    always_comb begin
        mode_next     = mode_press ? sfpc_pkg::next_mod3(mode_reg) : mode_reg;
        channel_next  = channel_press ? sfpc_pkg::next_mod3(channel_reg) : channel_reg;
        run_next      = run_reg ^ run_press;
        timebase_next = timebase_reg;
        volt_next     = volt_reg;
        trigger_next  = trigger_reg;
        // Route the pot to the parameter picked by the new mode
        unique case (mode_next)
            sfpc_pkg::MODE_TIMEBASE: begin
                timebase_next = mapped.timebase_us;
            end
            sfpc_pkg::MODE_VOLT: begin
                volt_next = mapped.volt_scale_mv;
            end
            sfpc_pkg::MODE_TRIGGER: begin
                trigger_next = mapped.pot_mv;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (take) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // Update panel state once per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_levels_reg <= 3'b111;
            mode_reg        <= sfpc_pkg::MODE_TIMEBASE;
            channel_reg     <= sfpc_pkg::CHAN_BOTH;
            run_reg         <= 1'b0;
            timebase_reg    <= sfpc_pkg::TIMEBASE_RESET;
            volt_reg        <= sfpc_pkg::VOLT_RESET;
            trigger_reg     <= sfpc_pkg::TRIGGER_RESET;
            out_valid_reg   <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (take) begin
                prev_levels_reg <= {hold_data.run_button_level,
                                    hold_data.channel_button_level,
                                    hold_data.mode_button_level};
                mode_reg        <= mode_next;
                channel_reg     <= channel_next;
                run_reg         <= run_next;
                timebase_reg    <= timebase_next;
                volt_reg        <= volt_next;
                trigger_reg     <= trigger_next;
            end
        end
    end

    // Load the result register; hold it while stalled
    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg.adjust_mode    <= mode_next;
            out_reg.channel_select <= channel_next;
            out_reg.running        <= run_next;
            out_reg.timebase_us    <= timebase_next;
            out_reg.volt_scale_mv  <= volt_next;
            out_reg.trigger_mv     <= trigger_next;
            out_reg.pot_mv         <= mapped.pot_mv;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

### sv/scope_front_panel_control.sv
// ============================================================================
// scope_front_panel_control
// Front panel poll handler: button edges, modes and pot-mapped parameters.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data carry one panel poll: three active-low button
//   levels and a 12-bit pot sample. m_valid/m_ready/m_data return exactly
//   one result per poll: mode, channel selection, run flag, the three
//   parameter registers and the current pot voltage.
//   Between input acceptance and m_valid lie the input register, which
//   captures the poll when it is accepted, and the result register, which
//   loads when the panel stage takes it. Throughput is one transaction per
//   cycle while m_ready stays high; the figure is set by the combinational
//   edge/scale logic between the two registers, which carries the panel
//   state from one poll to the next.
//   Reset (aresetn low at a clock edge) empties both registers, marks all
//   buttons released, selects timebase mode and both channels, stops
//   acquisition and loads timebase 1000 us, scale 1000 mV, trigger 1650 mV.
//   When the receiver stalls, the result holds and one more poll is
//   captured in the input register; s_ready then drops until m_ready
//   returns. No transaction is lost or repeated.
// ============================================================================
module scope_front_panel_control (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  sfpc_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output sfpc_pkg::out_t m_data
);

    logic             take;
    logic             hold_valid;
    sfpc_pkg::in_t    hold_data;
    sfpc_pkg::scale_t mapped;

    sfpc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .take       (take),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    sfpc_scale u_scale (
        .pot_sample (hold_data.pot_sample),
        .mapped     (mapped)
    );

    sfpc_panel u_panel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .hold_valid (hold_valid),
        .hold_data  (hold_data),
        .mapped     (mapped),
        .take       (take),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

### sv/sfpc_checker.sv
// ============================================================================
// sfpc_checker
// Port-level checks for the scope front panel, bound to the top level.
// ============================================================================
module sfpc_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input sfpc_pkg::out_t m_data
);

    // Reset empties the result side and opens the input
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not empty after reset");

    // Hold a stalled result transaction
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // Selectors never take the unused code
    a_sel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.adjust_mode <= sfpc_pkg::MODE_TRIGGER
                 && m_data.channel_select <= sfpc_pkg::CHAN_BOTH)
        else $error("selector out of range");

    // In trigger mode the trigger tracks the pot voltage
    a_trigger_track: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.adjust_mode == sfpc_pkg::MODE_TRIGGER
        |-> m_data.trigger_mv == m_data.pot_mv)
        else $error("trigger does not follow pot");

    // Mapped values stay inside their ranges
    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.pot_mv <= 12'd3300 && m_data.trigger_mv <= 12'd3300
                 && m_data.timebase_us >= 14'd100 && m_data.timebase_us <= 14'd10000
                 && m_data.volt_scale_mv >= 14'd500
                 && m_data.volt_scale_mv <= 14'd10000)
        else $error("mapped value out of range");

endmodule

bind scope_front_panel_control sfpc_checker u_sfpc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
